>>> design/log_linear_latency_histogram_assert.svh
// Assertion macros used by the histogram top level.
`ifndef LOG_LINEAR_LATENCY_HISTOGRAM_ASSERT_SVH
`define LOG_LINEAR_LATENCY_HISTOGRAM_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define LLH_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define LLH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> design/llh_pkg.sv
// Package: constants, types and bucket helpers of the latency histogram.
`timescale 1ns / 1ps
`default_nettype none
package llh_pkg;
   localparam int SAMPLE_WIDTH_DEF = 64;
   localparam int COUNT_WIDTH_DEF  = 32;
   localparam int NUM_BUCKETS      = 976;
   localparam int BUCKET_IDX_W     = 10;
   localparam int PERMILLE_W       = 10;
   localparam int EXACT_BUCKETS    = 32;
   localparam int SLOTS_PER_EXP    = 16;
   localparam int QUEUE_DEPTH      = 2;

   typedef enum logic {
      REQ_RECORD = 1'b0,
      REQ_QUERY  = 1'b1
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_REC_WRITE,
      ST_RANK,
      ST_SCAN,
      ST_SCAN_WAIT,
      ST_RESULT
   } back_state_type;

   // Queue entry from the front part to the back part.
   typedef struct packed {
      req_kind_type            kind;
      logic [BUCKET_IDX_W-1:0] bucket;
      logic [63:0]             sample;
      logic [PERMILLE_W-1:0]   permille;
   } cmd_type;

   // Index of the highest set bit of a 64-bit value (0 when zero).
   function automatic logic [5:0] top_bit(input logic [63:0] v);
      logic [5:0] e;
      e = 6'd0;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) e = 6'(i);
      end
      return e;
   endfunction

   // Bucket index of a sample.
   function automatic logic [BUCKET_IDX_W-1:0] bucket_of(input logic [63:0] v);
      logic [5:0]              e;
      logic [63:0]             sh;
      logic [BUCKET_IDX_W-1:0] b;
      e  = top_bit(v);
      sh = v >> (e - 6'd4);
      if (v < 64'(EXACT_BUCKETS)) b = BUCKET_IDX_W'(v);
      else b = BUCKET_IDX_W'(EXACT_BUCKETS) + BUCKET_IDX_W'({e - 6'd5, 4'd0})
               + BUCKET_IDX_W'(sh[3:0]);
      return b;
   endfunction

   // Upper bound of the bucket with exponent field and slot.
   function automatic logic [63:0] bucket_top(input logic [BUCKET_IDX_W-1:0] i);
      logic [BUCKET_IDX_W-1:0] d;
      logic [5:0]              e;
      logic [3:0]              slot;
      logic [63:0]             up;
      d    = i - BUCKET_IDX_W'(EXACT_BUCKETS);
      e    = 6'(d[BUCKET_IDX_W-1:4]) + 6'd5;
      slot = d[3:0];
      if (i < BUCKET_IDX_W'(EXACT_BUCKETS)) up = 64'(i);
      else if (e == 6'd63 && slot == 4'd15) up = '1;
      else up = (64'({1'b1, slot}) + 64'd1 << (e - 6'd4)) - 64'd1;
      return up;
   endfunction
endpackage
`default_nettype wire

>>> design/llh_if.sv
// Valid/ready channel interface carrying a payload struct.
`timescale 1ns / 1ps
`default_nettype none
interface llh_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> design/llh_front.sv
// Front part: accepts request beats and computes the bucket of a sample.
`timescale 1ns / 1ps
`default_nettype none
module llh_front #(
   parameter int SAMPLE_WIDTH = llh_pkg::SAMPLE_WIDTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic             req_type,
   input  wire logic [63:0]      req_sample_us,
   input  wire logic [9:0]       req_query_permille,
   output logic                  cmd_valid,
   input  wire logic             cmd_ready,
   output llh_pkg::cmd_type      cmd
);
   logic             valid_ff, valid_in;
   llh_pkg::cmd_type cmd_ff, cmd_in;
   logic [63:0]      sample;

   always_comb begin
      sample = req_sample_us;
      if (SAMPLE_WIDTH < 64) sample = req_sample_us & ((64'd1 << SAMPLE_WIDTH) - 64'd1);
   end

   assign req_ready = !valid_ff || cmd_ready;

   always_comb begin
      valid_in = valid_ff && !cmd_ready;
      cmd_in   = cmd_ff;
      if (req_valid && req_ready) begin
         valid_in        = 1'b1;
         cmd_in.kind     = llh_pkg::req_kind_type'(req_type);
         cmd_in.sample   = sample;
         cmd_in.bucket   = llh_pkg::bucket_of(sample);
         cmd_in.permille = req_query_permille;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      cmd_ff <= cmd_in;
   end

   assign cmd_valid = valid_ff;
   assign cmd       = cmd_ff;
endmodule
`default_nettype wire

>>> design/llh_queue.sv
// Short command queue between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none
module llh_queue (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  llh_pkg::cmd_type in_cmd,
   output logic             out_valid,
   input  wire logic        out_ready,
   output llh_pkg::cmd_type out_cmd
);
   llh_pkg::cmd_type slot_ff [llh_pkg::QUEUE_DEPTH];
   logic             wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             push, pop;

   assign in_ready  = cnt_ff != 2'(llh_pkg::QUEUE_DEPTH);
   assign out_valid = cnt_ff != 2'd0;
   assign out_cmd   = slot_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_in  = push ? !wr_ff : wr_ff;
      rd_in  = pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) slot_ff[wr_ff] <= in_cmd;
   end
endmodule
`default_nettype wire

>>> design/llh_back.sv
// Back part: bucket memory, record update, quantile scan and result register.
`timescale 1ns / 1ps
`default_nettype none
module llh_back #(
   parameter int COUNT_WIDTH = llh_pkg::COUNT_WIDTH_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         cmd_valid,
   output logic              cmd_ready,
   input  llh_pkg::cmd_type  cmd,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic [63:0]       rsp_quantile_us,
   output logic [31:0]       rsp_sample_count,
   output logic [63:0]       rsp_max_sample_us,
   output logic              rsp_count_saturated,
   output logic              busy_clear
);
   localparam int IW = llh_pkg::BUCKET_IDX_W;
   localparam logic [IW-1:0] LAST = IW'(llh_pkg::NUM_BUCKETS - 1);
   localparam logic [COUNT_WIDTH-1:0] CMAX = '1;
   localparam logic [COUNT_WIDTH+9:0] THOUSAND = (COUNT_WIDTH+10)'(1000);

   logic [COUNT_WIDTH-1:0] mem [llh_pkg::NUM_BUCKETS];
   logic [COUNT_WIDTH-1:0] rd_data_ff;

   llh_pkg::back_state_type state_ff, state_in;
   logic [IW-1:0]           idx_ff, idx_in;
   logic [COUNT_WIDTH-1:0]  total_ff, total_in;
   logic [63:0]             max_ff, max_in;
   logic                    sat_ff, sat_in;
   llh_pkg::cmd_type        cur_ff, cur_in;
   logic [COUNT_WIDTH+9:0]  rank_ff, rank_in;
   logic [COUNT_WIDTH+9:0]  sum_ff, sum_in;
   logic [63:0]             q_ff, q_in;
   logic                    rv_ff, rv_in;
   logic [63:0]             rq_ff, rm_ff;
   logic [31:0]             rc_ff;
   logic                    rs_ff;

   logic                    mem_we;
   logic [IW-1:0]           mem_wa, mem_ra;
   logic [COUNT_WIDTH-1:0]  mem_wd;
   logic [COUNT_WIDTH+9:0]  prod, sum_next;
   logic [63:0]             up;
   logic                    take;

   assign prod     = (COUNT_WIDTH+10)'(total_ff) * (COUNT_WIDTH+10)'(cur_ff.permille);
   // Running sum kept scaled by 1000 so it compares directly against count times permille.
   assign sum_next = sum_ff + (COUNT_WIDTH+10)'(rd_data_ff) * THOUSAND;
   assign up       = llh_pkg::bucket_top(idx_ff);
   assign take     = rv_ff && !rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         llh_pkg::ST_CLEAR:     if (idx_ff == LAST) state_in = llh_pkg::ST_IDLE;
         llh_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               if (cmd.kind == llh_pkg::REQ_QUERY) state_in = llh_pkg::ST_RANK;
               else if (total_ff != CMAX) state_in = llh_pkg::ST_REC_WRITE;
            end
         end
         llh_pkg::ST_REC_WRITE: state_in = llh_pkg::ST_IDLE;
         llh_pkg::ST_RANK: begin
            if (total_ff == '0 || cur_ff.permille == '0 ||
                cur_ff.permille > llh_pkg::PERMILLE_W'(1000)) state_in = llh_pkg::ST_RESULT;
            else state_in = llh_pkg::ST_SCAN_WAIT;
         end
         llh_pkg::ST_SCAN_WAIT: state_in = llh_pkg::ST_SCAN;
         llh_pkg::ST_SCAN: begin
            if (sum_next >= rank_ff || idx_ff == LAST) state_in = llh_pkg::ST_RESULT;
            else state_in = llh_pkg::ST_SCAN_WAIT;
         end
         llh_pkg::ST_RESULT:    if (!take) state_in = llh_pkg::ST_IDLE;
         default:               state_in = llh_pkg::ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      idx_in   = idx_ff;
      total_in = total_ff;
      max_in   = max_ff;
      sat_in   = sat_ff;
      cur_in   = cur_ff;
      rank_in  = rank_ff;
      sum_in   = sum_ff;
      q_in     = q_ff;
      rv_in    = rv_ff && !rsp_ready;
      mem_we   = 1'b0;
      mem_wa   = idx_ff;
      mem_wd   = '0;
      mem_ra   = idx_ff;
      cmd_ready = 1'b0;
      case (state_ff)
         llh_pkg::ST_CLEAR: begin
            mem_we = 1'b1;
            idx_in = idx_ff + IW'(1);
         end
         llh_pkg::ST_IDLE: begin
            cmd_ready = 1'b1;
            mem_ra    = cmd.bucket;
            if (cmd_valid) begin
               cur_in = cmd;
               if (cmd.kind == llh_pkg::REQ_RECORD && total_ff == CMAX) sat_in = 1'b1;
            end
         end
         llh_pkg::ST_REC_WRITE: begin
            mem_we   = 1'b1;
            mem_wa   = cur_ff.bucket;
            mem_wd   = rd_data_ff + COUNT_WIDTH'(1);
            total_in = total_ff + COUNT_WIDTH'(1);
            if (cur_ff.sample > max_ff) max_in = cur_ff.sample;
         end
         llh_pkg::ST_RANK: begin
            // Rank is met once 1000 times the sum reaches count times permille.
            rank_in = prod;
            sum_in  = '0;
            idx_in  = '0;
            q_in    = '0;
            mem_ra  = '0;
         end
         llh_pkg::ST_SCAN_WAIT: mem_ra = idx_ff;
         llh_pkg::ST_SCAN: begin
            sum_in = sum_next;
            q_in   = max_ff;
            if (sum_next >= rank_ff) q_in = (up < max_ff) ? up : max_ff;
            else idx_in = idx_ff + IW'(1);
         end
         llh_pkg::ST_RESULT: if (!take) rv_in = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= llh_pkg::ST_CLEAR;
         idx_ff   <= '0;
         total_ff <= '0;
         max_ff   <= '0;
         sat_ff   <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         total_ff <= total_in;
         max_ff   <= max_in;
         sat_ff   <= sat_in;
         rv_ff    <= rv_in;
      end
      cur_ff  <= cur_in;
      rank_ff <= rank_in;
      sum_ff  <= sum_in;
      q_ff    <= q_in;
      if (state_ff == llh_pkg::ST_RESULT && !take) begin
         rq_ff <= q_ff;
         rc_ff <= 32'(total_ff);
         rm_ff <= max_ff;
         rs_ff <= sat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rd_data_ff <= mem[mem_ra];
   end

   assign rsp_valid           = rv_ff;
   assign rsp_quantile_us     = rq_ff;
   assign rsp_sample_count    = rc_ff;
   assign rsp_max_sample_us   = rm_ff;
   assign rsp_count_saturated = rs_ff;
   assign busy_clear          = state_ff == llh_pkg::ST_CLEAR;
endmodule
`default_nettype wire

>>> design/log_linear_latency_histogram.sv
// Top level of the log-linear latency histogram.
//
// channel | dir | handshake             | payload
// req     | in  | req_valid / req_ready | req_type, req_sample_us, req_query_permille
// rsp     | out | rsp_valid / rsp_ready | rsp_quantile_us, rsp_sample_count,
//         |     |                       | rsp_max_sample_us, rsp_count_saturated
//
// A record reads its bucket in the back part, then writes it back incremented.
// A query computes its rank, then reads and checks the buckets in turn until the rank is met.
// After reset a clearing pass zeroes all 976 buckets of the memory; beats queue meanwhile.
// A stalled result holds in its register; the front and queue keep taking beats until full.
`timescale 1ns / 1ps
`default_nettype none
`include "log_linear_latency_histogram_assert.svh"
module log_linear_latency_histogram #(
   parameter int SAMPLE_WIDTH = llh_pkg::SAMPLE_WIDTH_DEF,
   parameter int COUNT_WIDTH  = llh_pkg::COUNT_WIDTH_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_type,
   input  wire logic [63:0] req_sample_us,
   input  wire logic [9:0]  req_query_permille,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_quantile_us,
   output logic [31:0]      rsp_sample_count,
   output logic [63:0]      rsp_max_sample_us,
   output logic             rsp_count_saturated
);
   llh_if #(.payload_type(llh_pkg::cmd_type)) f2q ();
   llh_if #(.payload_type(llh_pkg::cmd_type)) q2b ();
   logic busy_clear;

   llh_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_type, .req_sample_us,
      .req_query_permille,
      .cmd_valid(f2q.valid), .cmd_ready(f2q.ready), .cmd(f2q.payload)
   );

   llh_queue u_queue (
      .clock, .reset,
      .in_valid(f2q.valid), .in_ready(f2q.ready), .in_cmd(f2q.payload),
      .out_valid(q2b.valid), .out_ready(q2b.ready), .out_cmd(q2b.payload)
   );

   llh_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
      .clock, .reset,
      .cmd_valid(q2b.valid), .cmd_ready(q2b.ready), .cmd(q2b.payload),
      .rsp_valid, .rsp_ready, .rsp_quantile_us, .rsp_sample_count,
      .rsp_max_sample_us, .rsp_count_saturated, .busy_clear
   );

   `LLH_ASSERT_IMPL(a_no_rsp_in_clear, clock, reset, busy_clear, !rsp_valid)
   `LLH_ASSERT_NEXT(a_sat_sticky, clock, reset, rsp_valid && rsp_ready && rsp_count_saturated,
      !rsp_valid || rsp_count_saturated)
   `LLH_ASSERT_IMPL(a_q_capped, clock, reset, rsp_valid, rsp_quantile_us <= rsp_max_sample_us)
endmodule
`default_nettype wire

>>> verif/llh_tb_pkg.sv
// Beat types shared by the histogram testbench files.
`timescale 1ns / 1ps
package llh_tb_pkg;
   import llh_pkg::*;

   typedef struct packed {
      req_kind_type kind;
      logic [63:0]  sample_us;
      logic [9:0]   permille;
   } hist_req_type;

   typedef struct packed {
      logic [63:0] quantile_us;
      logic [31:0] sample_count;
      logic [63:0] max_sample_us;
      logic        saturated;
   } hist_rsp_type;
endpackage

>>> verif/log_linear_latency_histogram_checker.sv
// Checker: tracks the histogram contents and compares every query answer.
`timescale 1ns / 1ps
module log_linear_latency_histogram_checker
   import llh_pkg::*;
   import llh_tb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  hist_req_type req_beat,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  hist_rsp_type rsp_beat,
   output int           fail_count,
   output int           answers_pending
);
   bit [31:0]    hist_bins[NUM_BUCKETS];
   bit [31:0]    total_samples;
   bit [63:0]    peak_sample;
   bit           dropped;
   hist_rsp_type answer_queue[$];

   function automatic int bin_index(bit [63:0] v);
      int e;
      e = 0;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) e = i;
      end
      if (v < 64'd32) return int'(v);
      return 32 + (e - 5) * 16 + int'(v >> (e - 4)) - 16;
   endfunction

   function automatic bit [63:0] bin_upper(int i);
      int e, slot;
      if (i < 32) return 64'(i);
      e    = (i - 32) / 16 + 5;
      slot = (i - 32) % 16;
      if (e == 63 && slot == 15) return '1;
      return (64'(17 + slot) << (e - 4)) - 64'd1;
   endfunction

   function automatic hist_rsp_type answer_query(bit [9:0] p);
      hist_rsp_type a;
      bit [63:0]    rank, acc, hi, lo, up;
      a.quantile_us = '0;
      if (total_samples != 0 && p >= 1 && p <= 1000) begin
         hi   = total_samples / 1000;
         lo   = total_samples % 1000;
         rank = hi * p + (lo * p + 999) / 1000;
         acc  = 0;
         a.quantile_us = peak_sample;
         for (int i = 0; i < NUM_BUCKETS; i++) begin
            acc += hist_bins[i];
            if (acc >= rank) begin
               up = bin_upper(i);
               a.quantile_us = (up < peak_sample) ? up : peak_sample;
               break;
            end
         end
      end
      a.sample_count  = total_samples;
      a.max_sample_us = peak_sample;
      a.saturated     = dropped;
      return a;
   endfunction

   assign answers_pending = answer_queue.size();

   always @(posedge clock) begin
      hist_rsp_type want;
      int b;
      if (reset) begin
         foreach (hist_bins[i]) hist_bins[i] = '0;
         total_samples = '0;
         peak_sample   = '0;
         dropped       = 1'b0;
         answer_queue.delete();
         fail_count    = 0;
      end else begin
         if (req_valid && req_ready) begin
            if (req_beat.kind == REQ_RECORD) begin
               if (total_samples == 32'hFFFF_FFFF) begin
                  dropped = 1'b1;
               end else begin
                  b = bin_index(req_beat.sample_us);
                  hist_bins[b]++;
                  total_samples++;
                  if (req_beat.sample_us > peak_sample) peak_sample = req_beat.sample_us;
               end
            end else begin
               answer_queue.push_back(answer_query(req_beat.permille));
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (answer_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected result beat %p", rsp_beat);
            end else begin
               want = answer_queue.pop_front();
               if (want !== rsp_beat) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: expected %p, got %p", want, rsp_beat);
               end
            end
         end
      end
   end
endmodule

>>> verif/log_linear_latency_histogram_tb.sv
// Testbench top: drives records and queries, stalls the result side, reports.
`timescale 1ns / 1ps
module log_linear_latency_histogram_tb;
   import llh_pkg::*;
   import llh_tb_pkg::*;

   logic clock;
   logic reset;
   int   fail_count, answers_pending, answers_taken, records_sent, queries_sent;
   bit   stimulus_done;

   llh_if #(.payload_type(hist_req_type)) req_ch ();
   llh_if #(.payload_type(hist_rsp_type)) rsp_ch ();

   log_linear_latency_histogram i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_ch.valid),
      .req_ready          (req_ch.ready),
      .req_type           (req_ch.payload.kind),
      .req_sample_us      (req_ch.payload.sample_us),
      .req_query_permille (req_ch.payload.permille),
      .rsp_valid          (rsp_ch.valid),
      .rsp_ready          (rsp_ch.ready),
      .rsp_quantile_us    (rsp_ch.payload.quantile_us),
      .rsp_sample_count   (rsp_ch.payload.sample_count),
      .rsp_max_sample_us  (rsp_ch.payload.max_sample_us),
      .rsp_count_saturated(rsp_ch.payload.saturated)
   );

   log_linear_latency_histogram_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_ch.valid),
      .req_ready      (req_ch.ready),
      .req_beat       (req_ch.payload),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp_beat       (rsp_ch.payload),
      .fail_count     (fail_count),
      .answers_pending(answers_pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Spread samples over all exponents, plus some small and fully random ones.
   function automatic logic [63:0] pick_sample();
      int e;
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 3))
         0: return 64'($urandom_range(0, 40));
         1: return v;
         default: begin
            e = $urandom_range(0, 63);
            return (v & ((64'd1 << e) - 64'd1)) | (64'd1 << e);
         end
      endcase
   endfunction

   task automatic send(req_kind_type kind, logic [63:0] s, logic [9:0] p);
      int gap;
      req_ch.payload = '{kind: kind, sample_us: s, permille: p};
      req_ch.valid   = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      if (kind == REQ_RECORD) records_sent++;
      else queries_sent++;
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Result side: random stalls, and one long hold-off early on.
   initial begin
      int gap;
      bit held;
      held = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && answers_taken >= 4) begin
            held = 1'b1;
            rsp_ch.ready = 1'b0;
            repeat (3000) @(negedge clock);
         end
         gap = pick_gap();
         rsp_ch.ready = (gap == 0);
         if (gap > 0) repeat (gap - 1) @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) answers_taken++;
   end

   initial begin
      logic [63:0] dir_samples[9];
      logic [9:0]  dir_permille[8];
      int waited;
      dir_samples  = '{64'd0, 64'd31, 64'd32, 64'd33, 64'd63, 64'd64,
                       64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 64'd1000};
      dir_permille = '{10'd0, 10'd1, 10'd500, 10'd999, 10'd1000, 10'd1001, 10'd1023, 10'd900};
      answers_taken = 0;
      records_sent  = 0;
      queries_sent  = 0;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      reset = 1'b1;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // empty histogram first, then the edges of both fields
      send(REQ_QUERY, '0, 10'd500);
      foreach (dir_samples[i]) send(REQ_RECORD, dir_samples[i], '0);
      foreach (dir_permille[i]) send(REQ_QUERY, 64'hFFFF_FFFF_FFFF_FFFF, dir_permille[i]);

      for (int n = 0; n < 1400; n++) begin
         if ($urandom_range(0, 99) < 12)
            send(REQ_QUERY, pick_sample(),
                 ($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, 1023))
                                             : 10'($urandom_range(1, 1000)));
         else
            send(REQ_RECORD, pick_sample(), 10'($urandom_range(0, 1023)));
      end
      req_ch.valid = 1'b0;

      waited = 0;
      while (answers_pending != 0 && waited < 200000) begin
         @(negedge clock);
         waited++;
      end
      repeat (2100) @(negedge clock);
      $display("covered %0d records and %0d quantile queries, %0d answers checked",
               records_sent, queries_sent, answers_taken);
      if (fail_count == 0 && answers_pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #60ms;
      $display("timeout");
      $display("simulation failed");
      $finish;
   end
endmodule
